>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level substring module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the default clock and reset of a module.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/lcrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrs_pkg
// Shared types and constants of the longest common or repeat substring block.
// ----------------------------------------------------------------------------
package lcrs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgNumSeqs = 2'd0;
  localparam logic [1:0] CfgSeqLen  = 2'd1;

  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned NumSeqsW  = 4;
  localparam int unsigned SeqLenW   = 11;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;  // shift a base of the column sequence up the chain
    logic row;    // evaluate one row of the run table
    logic self;   // the pair is a sequence with itself
    logic drain;  // shift the per-cell best records up the chain
  } cell_ctl_t;

endpackage

>>> hw/rtl/lcrs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrs_cell
// One column of the run table: holds one base, its run and a best record.
// ----------------------------------------------------------------------------
module lcrs_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 10,
  parameter int unsigned LW  = 11,
  parameter int unsigned SW  = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcrs_pkg::cell_ctl_t    ctl_i,
  input  logic [1:0]             ch_i,
  output logic [1:0]             ch_o,
  input  logic [1:0]             sb_i,
  input  logic [AW-1:0]          kk_i,
  input  logic [LW-1:0]          n_i,
  input  logic [SW-1:0]          pa_i,
  input  logic [SW-1:0]          pb_i,
  input  logic [LW-1:0]          run_i,
  output logic [LW-1:0]          run_o,
  input  logic [LW+2*SW+3*AW-1:0] rec_i,
  output logic [LW+2*SW+3*AW-1:0] rec_o
);
  import lcrs_pkg::*;

  localparam int unsigned RW = LW + 2*SW + 3*AW;

  logic [1:0]    ch_q;
  logic [LW-1:0] run_q, run_d;
  logic [RW-1:0] rec_q, rec_d;
  logic [LW:0]   m_w, kk_w, run_w;
  logic [LW-1:0] run_new;
  logic          match, apart, take;

  assign m_w     = (LW+1)'(IDX);
  assign kk_w    = (LW+1)'(kk_i);
  assign run_new = run_i + LW'(1);
  assign run_w   = {1'b0, run_new};

  always_comb begin
    match = ctl_i.row && (m_w < {1'b0, n_i}) && (ch_q == sb_i) &&
            !(ctl_i.self && (kk_i == AW'(IDX)));
    // For a repeat the two copies must not overlap.
    apart = !ctl_i.self || ((m_w + run_w) < (kk_w + (LW+1)'(1))) ||
            ((kk_w + run_w) < (m_w + (LW+1)'(1)));
    take  = match && apart && (run_new >= rec_q[RW-1 -: LW]);
    run_d = run_q;
    rec_d = rec_q;
    if (ctl_i.shift) begin
      run_d = '0;
    end else if (ctl_i.row) begin
      run_d = match ? run_new : '0;
    end
    if (ctl_i.drain) begin
      rec_d = rec_i;
    end else if (take) begin
      rec_d = {run_new, pa_i, pb_i, kk_i,
               AW'(m_w + (LW+1)'(1) - run_w),
               AW'(kk_w + (LW+1)'(1) - run_w)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      run_q <= '0;
      rec_q <= '0;
    end else begin
      if (ctl_i.shift) begin
        ch_q <= ch_i;
      end
      run_q <= run_d;
      rec_q <= rec_d;
    end
  end

  assign ch_o  = ch_q;
  assign run_o = run_q;
  assign rec_o = rec_q;

endmodule

>>> hw/rtl/longest_common_or_repeat_substring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_common_or_repeat_substring
// Loads a set of base sequences and finds the longest common substring of
// any two of them or the longest non-overlapping repeat within one.
// ----------------------------------------------------------------------------
//
//   channel   signals                                     direction
//   input     start_i, busy_o, base_i                     in (one base a word)
//   result    valid_o, best_len_o, start_first_o,         out (one word a set)
//             start_second_o, seq_first_o, seq_second_o
//   config    cfg_valid_i, cfg_ready_o, cfg_addr_i,       in
//             cfg_data_i
//
// Bases are taken one a cycle while busy_o is low. The word that completes
// the set starts the scan. With N sequences of n bases, each of the
// N(N+1)/2 pairs takes two phases: StLoadA shifts the column sequence into
// the cell chain through the single read port of the sequence memory, and
// StRows streams the row sequence, one row of the run table a cycle. Then
// StFlush lets the last row settle, StDrain shifts the per-cell best
// records out of the chain, and the result word shows once the drain ends.
// The result cannot be stalled. Register writes are taken only while idle
// and in a cycle that offers no base.
// Reset clears all control state and the cell chain; the sequence memory
// is only read after it was written in the current load.
module longest_common_or_repeat_substring #(
  parameter int unsigned MAX_SEQS = 8,
  parameter int unsigned MAX_LEN  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          base_i,
  output logic                                valid_o,
  output logic [$clog2(MAX_LEN+1)-1:0]        best_len_o,
  output logic [$clog2(MAX_LEN)-1:0]          start_first_o,
  output logic [$clog2(MAX_LEN)-1:0]          start_second_o,
  output logic [$clog2(MAX_SEQS)-1:0]         seq_first_o,
  output logic [$clog2(MAX_SEQS)-1:0]         seq_second_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lcrs_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [lcrs_pkg::CfgDataW-1:0]       cfg_data_i
);
  import lcrs_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW  = $clog2(MAX_LEN);
  localparam int unsigned LW  = $clog2(MAX_LEN+1);
  localparam int unsigned SW  = $clog2(MAX_SEQS);
  localparam int unsigned SNW = $clog2(MAX_SEQS+1);
  localparam int unsigned RW  = LW + 2*SW + 3*AW;
  localparam int unsigned MW  = SW + AW;
  localparam int unsigned KW  = LW + 2*SW + AW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoadA = 3'd1;
  localparam logic [2:0] StRows  = 3'd2;
  localparam logic [2:0] StFlush = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [SNW-1:0] nseq_q, nseq_d;
  logic [LW-1:0]  n_q, n_d;
  logic [SW-1:0]  lseq_q, lseq_d;
  logic [AW-1:0]  lpos_q, lpos_d;
  logic [SW-1:0]  pa_q, pa_d, pb_q, pb_d;
  logic [AW-1:0]  cnt_q, cnt_d;
  logic           op_shift_q, op_row_q, self_q, valid_q;
  logic [AW-1:0]  kk_q;
  logic [SW-1:0]  opa_q, opb_q;
  logic [RW-1:0]  best_q, best_d;
  logic [1:0]     rd_q;
  logic           cfg_fire, in_fire, last_base, last_idx, issue_shift, issue_row;
  logic [MW-1:0]  raddr;
  int unsigned    cv;

  // Sequence memory, one row of 2**AW entries per sequence.
  logic [1:0] mem_q [2**MW];

  assign busy_o      = (state_q != StIdle);
  // A base offered in the same cycle goes first; the write waits until no base is offered.
  assign cfg_ready_o = ~busy_o & ~start_i;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = start_i & ~busy_o;
  assign last_base   = (SNW'(lseq_q) + SNW'(1) == nseq_q) &&
                       (LW'(lpos_q) + LW'(1) == n_q);
  assign last_idx    = (LW'(cnt_q) + LW'(1) == n_q);
  assign issue_shift = (state_q == StLoadA);
  assign issue_row   = (state_q == StRows);
  assign raddr       = issue_shift ? {pa_q, cnt_q} : {pb_q, cnt_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_q[{lseq_q, lpos_q}] <= base_i;
    end
    rd_q <= mem_q[raddr];
  end

  // Cell chain.
  cell_ctl_t     ctl;
  logic [1:0]    ch   [MAX_LEN+1];
  logic [LW-1:0] run  [MAX_LEN+1];
  logic [RW-1:0] rec  [MAX_LEN+1];

  assign ctl.shift = op_shift_q;
  assign ctl.row   = op_row_q;
  assign ctl.self  = self_q;
  assign ctl.drain = (state_q == StDrain);
  assign ch[0]     = rd_q;
  assign run[0]    = '0;
  assign rec[0]    = '0;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    lcrs_cell #(.IDX(g), .AW(AW), .LW(LW), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .ch_i   (ch[g]),
      .ch_o   (ch[g+1]),
      .sb_i   (rd_q),
      .kk_i   (kk_q),
      .n_i    (n_q),
      .pa_i   (opa_q),
      .pb_i   (opb_q),
      .run_i  (run[g]),
      .run_o  (run[g+1]),
      .rec_i  (rec[g]),
      .rec_o  (rec[g+1])
    );
  end

  // Control sequencer.
  always_comb begin
    state_d = state_q;
    nseq_d  = nseq_q;
    n_d     = n_q;
    lseq_d  = lseq_q;
    lpos_d  = lpos_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    cnt_d   = cnt_q;
    best_d  = best_q;
    cv      = 0;
    case (state_q)
      StIdle: begin
        if (cfg_fire) begin
          // Writes to unused indexes change nothing, the load included.
          if (cfg_addr_i == CfgNumSeqs) begin
            lseq_d = '0;
            lpos_d = '0;
            cv = 32'(cfg_data_i[NumSeqsW-1:0]);
            if (cv < 2) cv = 2;
            if (cv > MAX_SEQS) cv = MAX_SEQS;
            nseq_d = SNW'(cv);
          end else if (cfg_addr_i == CfgSeqLen) begin
            lseq_d = '0;
            lpos_d = '0;
            cv = 32'(cfg_data_i[SeqLenW-1:0]);
            if (cv < 1) cv = 1;
            if (cv > MAX_LEN) cv = MAX_LEN;
            n_d = LW'(cv);
          end
        end else if (in_fire) begin
          if (last_base) begin
            lseq_d  = '0;
            lpos_d  = '0;
            pa_d    = '0;
            pb_d    = '0;
            cnt_d   = AW'(n_q - LW'(1));
            state_d = StLoadA;
          end else if (LW'(lpos_q) + LW'(1) == n_q) begin
            lpos_d = '0;
            lseq_d = lseq_q + SW'(1);
          end else begin
            lpos_d = lpos_q + AW'(1);
          end
        end
      end
      StLoadA: begin
        if (cnt_q == '0) begin
          state_d = StRows;
        end else begin
          cnt_d = cnt_q - AW'(1);
        end
      end
      StRows: begin
        if (last_idx) begin
          cnt_d = AW'(n_q - LW'(1));
          if (SNW'(pb_q) + SNW'(1) == nseq_q) begin
            if (SNW'(pa_q) + SNW'(1) == nseq_q) begin
              state_d = StFlush;
            end else begin
              pa_d    = pa_q + SW'(1);
              pb_d    = pa_q + SW'(1);
              state_d = StLoadA;
            end
          end else begin
            pb_d    = pb_q + SW'(1);
            state_d = StLoadA;
          end
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      StFlush: begin
        cnt_d   = '0;
        best_d  = '0;
        state_d = StDrain;
      end
      StDrain: begin
        // Records leave in falling column order, so on equal keys the
        // one seen first (the later column) stays.
        if (rec[MAX_LEN][RW-1 -: KW] > best_q[RW-1 -: KW]) begin
          best_d = rec[MAX_LEN];
        end
        if (cnt_q == AW'(MAX_LEN-1)) begin
          state_d = StIdle;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      nseq_q     <= SNW'(2);
      n_q        <= LW'((MAX_LEN < 1024) ? MAX_LEN : 1024);
      lseq_q     <= '0;
      lpos_q     <= '0;
      pa_q       <= '0;
      pb_q       <= '0;
      cnt_q      <= '0;
      best_q     <= '0;
      op_shift_q <= 1'b0;
      op_row_q   <= 1'b0;
      self_q     <= 1'b0;
      kk_q       <= '0;
      opa_q      <= '0;
      opb_q      <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      nseq_q     <= nseq_d;
      n_q        <= n_d;
      lseq_q     <= lseq_d;
      lpos_q     <= lpos_d;
      pa_q       <= pa_d;
      pb_q       <= pb_d;
      cnt_q      <= cnt_d;
      best_q     <= best_d;
      // The memory read is registered, so the operation is registered too and trails its read.
      op_shift_q <= issue_shift;
      op_row_q   <= issue_row;
      self_q     <= (pa_q == pb_q);
      kk_q       <= cnt_q;
      opa_q      <= pa_q;
      opb_q      <= pb_q;
      valid_q    <= (state_q == StDrain) && (cnt_q == AW'(MAX_LEN-1));
    end
  end

  assign valid_o        = valid_q;
  assign best_len_o     = best_q[RW-1 -: LW];
  assign seq_first_o    = best_q[RW-LW-1 -: SW];
  assign seq_second_o   = best_q[RW-LW-SW-1 -: SW];
  assign start_first_o  = best_q[2*AW-1 -: AW];
  assign start_second_o = best_q[AW-1:0];

  `ASSERT_DEF(a_result_then_load, (valid_o |=> !busy_o), "scan resumed after result")
  `ASSERT_DEF(a_scan_after_base, ($rose(busy_o) |-> $past(start_i)), "scan without base")
  `ASSERT_DEF(a_cfg_clears_load, (cfg_fire && (cfg_addr_i == CfgNumSeqs || cfg_addr_i == CfgSeqLen) |=> (lpos_q == '0 && lseq_q == '0)), "load position kept over config write")
  `ASSERT_DEF(a_row_in_range, (issue_row |-> (LW'(cnt_q) < n_q)), "row index out of range")

endmodule

>>> tb/tb_longest_common_or_repeat_substring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_common_or_repeat_substring
// Loads sequence sets into the substring finder under random sender gaps,
// predicts every result word with an in-bench dynamic program, and checks
// each result word field by field as it appears.
// ----------------------------------------------------------------------------
module tb_longest_common_or_repeat_substring;
  import lcrs_pkg::*;

  localparam int unsigned MaxSeqs = 8;
  localparam int unsigned MaxLen  = 1024;
  localparam int unsigned Quiet   = 16;

  // One entry of the stimulus list: either a base word or a register write.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  addr;
    logic [10:0] data;
    logic [1:0]  base;
    int          idle_pct;
  } bus_op_t;

  typedef struct packed {
    logic [10:0] len;
    logic [9:0]  start_a;
    logic [9:0]  start_b;
    logic [2:0]  seq_a;
    logic [2:0]  seq_b;
  } match_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  base_i = '0;
  logic        valid_o;
  logic [10:0] best_len_o;
  logic [9:0]  start_first_o;
  logic [9:0]  start_second_o;
  logic [2:0]  seq_first_o;
  logic [2:0]  seq_second_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  longest_common_or_repeat_substring #(
    .MAX_SEQS(MaxSeqs),
    .MAX_LEN (MaxLen)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .base_i        (base_i),
    .valid_o       (valid_o),
    .best_len_o    (best_len_o),
    .start_first_o (start_first_o),
    .start_second_o(start_second_o),
    .seq_first_o   (seq_first_o),
    .seq_second_o  (seq_second_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  bus_op_t pending_ops[$];
  match_t  expected_matches[$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  longint  cycle_count = 0;
  longint  cycle_budget = 0;
  int      base_count = 0;
  bit      base_taken = 1'b0;
  bit      cfg_taken = 1'b0;

  // Predictor state: its own copy of the store, the load position and the
  // two configuration values after masking and clamping.
  logic [1:0] bank[MaxSeqs][MaxLen];
  int         loaded = 0;
  int         n_seqs = 2;
  int         n_len  = MaxLen;

  function automatic void apply_reg_write(logic [1:0] addr, logic [10:0] data);
    int v;
    if (addr == CfgNumSeqs) begin
      v = int'(data & 11'hF);
      if (v < 2) v = 2;
      if (v > MaxSeqs) v = MaxSeqs;
      n_seqs = v;
      loaded = 0;
    end else if (addr == CfgSeqLen) begin
      v = int'(data);
      if (v < 1) v = 1;
      if (v > MaxLen) v = MaxLen;
      n_len = v;
      loaded = 0;
    end
  endfunction

  // Runs the diagonal-run table over every pair i <= j. On the self pair the
  // main diagonal is forced to zero and a run counts only if its two copies
  // do not overlap. Ties go to the later run in scan order.
  function automatic match_t find_best_match();
    int     prev[MaxLen+1];
    int     cur[MaxLen+1];
    int     run;
    bit     self_pair;
    match_t m;
    int     best;
    m = '0;
    best = 0;
    for (int a = 0; a < n_seqs; a++) begin
      for (int b = a; b < n_seqs; b++) begin
        self_pair = (a == b);
        for (int l = 0; l <= n_len; l++) prev[l] = 0;
        for (int k = 1; k <= n_len; k++) begin
          cur[0] = 0;
          for (int l = 1; l <= n_len; l++) begin
            run = 0;
            if (!(self_pair && k == l) && bank[a][l-1] == bank[b][k-1]) begin
              run = prev[l-1] + 1;
              if (run >= best &&
                  (!self_pair || (l - 1 + run < k) || (k - 1 + run < l))) begin
                best      = run;
                m.len     = 11'(run);
                m.start_a = 10'(l - run);
                m.start_b = 10'(k - run);
                m.seq_a   = 3'(a);
                m.seq_b   = 3'(b);
              end
            end
            cur[l] = run;
          end
          for (int l = 0; l <= n_len; l++) prev[l] = cur[l];
        end
      end
    end
    return m;
  endfunction

  function automatic void load_base(logic [1:0] b);
    bank[loaded / n_len][loaded % n_len] = b;
    loaded++;
    if (loaded == n_seqs * n_len) begin
      loaded = 0;
      expected_matches.push_back(find_best_match());
    end
  endfunction

  // Monitor: sees both handshakes and the result strobe at the rising edge.
  always @(posedge clk_i) begin
    match_t want;
    cycle_count++;
    if (cycle_count > cycle_budget && cycle_budget > 0) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      base_taken <= rst_ni && start_i && !busy_o;
      cfg_taken  <= rst_ni && cfg_valid_i && cfg_ready_o;
      if (rst_ni && cfg_valid_i && cfg_ready_o) apply_reg_write(cfg_addr_i, cfg_data_i);
      if (rst_ni && start_i && !busy_o) load_base(base_i);
      if (rst_ni && valid_o) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected result word len=%0d", $time, best_len_o);
          error_count++;
        end else begin
          want = expected_matches.pop_front();
          if (best_len_o !== want.len) begin
            $display("%0t: best_len expected %0d actual %0d", $time, want.len, best_len_o);
            error_count++;
          end
          if (start_first_o !== want.start_a) begin
            $display("%0t: start_first expected %0d actual %0d",
                     $time, want.start_a, start_first_o);
            error_count++;
          end
          if (start_second_o !== want.start_b) begin
            $display("%0t: start_second expected %0d actual %0d",
                     $time, want.start_b, start_second_o);
            error_count++;
          end
          if (seq_first_o !== want.seq_a) begin
            $display("%0t: seq_first expected %0d actual %0d", $time, want.seq_a, seq_first_o);
            error_count++;
          end
          if (seq_second_o !== want.seq_b) begin
            $display("%0t: seq_second expected %0d actual %0d",
                     $time, want.seq_b, seq_second_o);
            error_count++;
          end
        end
      end
      // Register writes wait for a stretch with nothing outstanding.
      if (expected_matches.size() == 0 && !busy_o) quiet_cycles <= quiet_cycles + 1;
      else quiet_cycles <= 0;
    end
  end

  // Driver: retires the word taken at the last rising edge, then presents
  // the next one, or a gap, at the falling edge.
  always @(negedge clk_i) begin
    bus_op_t op;
    bit      hold;
    if (rst_ni) begin
      hold = 1'b0;
      if (start_i && base_taken) void'(pending_ops.pop_front());
      else if (start_i) hold = 1'b1;
      if (cfg_valid_i && cfg_taken) void'(pending_ops.pop_front());
      else if (cfg_valid_i) hold = 1'b1;
      if (!hold) begin
        if (pending_ops.size() == 0) begin
          start_i     <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else begin
          op = pending_ops[0];
          if (op.is_cfg) begin
            start_i <= 1'b0;
            if (quiet_cycles >= Quiet) begin
              cfg_valid_i <= 1'b1;
              cfg_addr_i  <= op.addr;
              cfg_data_i  <= op.data;
            end else begin
              cfg_valid_i <= 1'b0;
            end
          end else begin
            cfg_valid_i <= 1'b0;
            if ($urandom_range(0, 99) < op.idle_pct) begin
              start_i <= 1'b0;
              base_i  <= 2'($urandom);
            end else begin
              start_i <= 1'b1;
              base_i  <= op.base;
            end
          end
        end
      end
    end
  end

  task automatic add_reg_write(logic [1:0] addr, logic [10:0] data);
    bus_op_t op;
    op = '{is_cfg: 1'b1, addr: addr, data: data, base: 2'd0, idle_pct: 0};
    pending_ops.push_back(op);
    cycle_budget += 200;
  endtask

  task automatic add_base(logic [1:0] b, int pct);
    bus_op_t op;
    op = '{is_cfg: 1'b0, addr: 2'd0, data: 11'd0, base: b, idle_pct: pct};
    pending_ops.push_back(op);
    base_count++;
    cycle_budget += 60;
  endtask

  // One full set of bases: later sequences are often mutated copies of
  // earlier ones, and some carry an internal repeat, so long runs occur.
  task automatic add_set(int ns, int len, int pct);
    logic [1:0] seqs[MaxSeqs][MaxLen];
    int src, shift, half;
    for (int s = 0; s < ns; s++) begin
      for (int p = 0; p < len; p++) seqs[s][p] = 2'($urandom);
      if (s > 0 && $urandom_range(0, 2) != 0) begin
        src = $urandom_range(0, s - 1);
        shift = $urandom_range(0, len - 1);
        for (int p = 0; p < len; p++) begin
          seqs[s][p] = seqs[src][(p + shift) % len];
          if ($urandom_range(0, 5) == 0) seqs[s][p] = 2'($urandom);
        end
      end
      if ($urandom_range(0, 3) == 0 && len >= 2) begin
        half = len / 2;
        for (int p = 0; p < half; p++) seqs[s][half + p] = seqs[s][p];
      end
    end
    for (int s = 0; s < ns; s++)
      for (int p = 0; p < len; p++) add_base(seqs[s][p], pct);
    cycle_budget += ns * (ns + 1) * len + MaxLen + 64;
  endtask

  initial begin
    int raw_n, raw_l, ns, len, pct;
    bit big_done;
    big_done = 1'b0;

    // Directed part. Out-of-range writes clamp to eight sequences of one
    // base, so every base value meets its twin across sequences.
    add_reg_write(CfgNumSeqs, 11'd15);
    add_reg_write(CfgSeqLen, 11'd0);
    add_base(2'd0, 0); add_base(2'd1, 0); add_base(2'd2, 0); add_base(2'd3, 0);
    add_base(2'd3, 0); add_base(2'd2, 0); add_base(2'd1, 0); add_base(2'd0, 0);
    // No match across the two sequences: only repeats within each one count.
    add_reg_write(CfgNumSeqs, 11'd2);
    add_reg_write(CfgSeqLen, 11'd4);
    for (int p = 0; p < 4; p++) add_base(2'd0, 0);
    for (int p = 0; p < 4; p++) add_base(2'd1, 0);
    // A partial load abandoned by a register write.
    add_reg_write(CfgNumSeqs, 11'd3);
    add_base(2'd3, 0); add_base(2'd2, 0);
    add_reg_write(CfgSeqLen, 11'd3);
    add_reg_write(CfgNumSeqs, 11'd2);
    // Identical sequences give a full-length common run.
    add_base(2'd3, 0); add_base(2'd2, 0); add_base(2'd0, 0);
    add_base(2'd3, 0); add_base(2'd2, 0); add_base(2'd0, 0);

    // Random part: gaps 30 percent, then 57 percent, then none.
    while (base_count < 1750) begin
      pct = (base_count < 600) ? 30 : (base_count < 1200) ? 57 : 0;
      if (!big_done && base_count >= 1300) begin
        // Two long sequences, the count register written out of range.
        add_reg_write(CfgNumSeqs, 11'd0);
        add_reg_write(CfgSeqLen, 11'd200);
        add_set(2, 200, 0);
        big_done = 1'b1;
      end else begin
        raw_n = $urandom_range(0, 15);
        raw_l = $urandom_range(0, 16);
        if ($urandom_range(0, 9) == 0) raw_l = $urandom_range(17, 40);
        ns  = (raw_n < 2) ? 2 : (raw_n > MaxSeqs) ? MaxSeqs : raw_n;
        len = (raw_l < 1) ? 1 : raw_l;
        add_reg_write(CfgNumSeqs, 11'(raw_n));
        add_reg_write(CfgSeqLen, 11'(raw_l));
        for (int r = $urandom_range(1, 3); r > 0; r--) add_set(ns, len, pct);
      end
    end
    cycle_budget = 4 * cycle_budget + 100000;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || expected_matches.size() != 0) @(posedge clk_i);
    repeat (MaxLen + 64) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
